### design/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg
// shared types and constants of the heat diffusion stencil step block
// ----------------------------------------------------------------------------
package hds_pkg;

  // register map, word index on the configuration port
  typedef enum logic [2:0] {
    REG_COLUMN_COUNT = 3'd0,
    REG_ROW_COUNT    = 3'd1,
    REG_TIME_STEP    = 3'd2,
    REG_X_GAIN       = 3'd3,
    REG_Y_GAIN       = 3'd4
  } hds_reg_t;

  localparam int CNT_W       = 11;
  localparam int COEF_W      = 16;
  localparam int DATA_W      = 32;
  localparam int MIN_COUNT   = 3;
  localparam int COUNT_RESET = 64;
  localparam int ADDR_W      = 5;

  typedef struct packed {
    logic [CNT_W-1:0]  column_count;
    logic [CNT_W-1:0]  row_count;
    logic [COEF_W-1:0] time_step;
    logic [COEF_W-1:0] x_gain;
    logic [COEF_W-1:0] y_gain;
  } hds_cfg_t;

  // stencil window: four cells and the source rate
  typedef struct packed {
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] centre;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] down;
    logic [DATA_W-1:0] src;
  } hds_win_t;

  // one column entry of the three row stores
  typedef struct packed {
    logic [DATA_W-1:0] upper;
    logic [DATA_W-1:0] middle;
    logic [DATA_W-1:0] source;
  } hds_line_t;

endpackage

### design/heat_diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step
// one explicit diffusion time step over a raster-streamed grid
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one grid cell per transfer in raster
//   order: cell_value and source_rate, both signed q16.16
//   output channel (out_valid/out_ready) gives one updated interior cell per
//   transfer with its row and column; last_cell marks the final one of a pass
//   input (r,c) with r,c >= 2 yields interior cell (r-1,c-1); other inputs
//   give no result; the ring of boundary cells counts as zero
//   configuration over apb: column_count, row_count, time_step, x_gain,
//   y_gain; writing a count restarts the pass at cell (0,0)
// timing
//   one transfer per cycle sustained while the output does not stall; a result
//   is presented after the input transfer that completes it (that edge loads
//   the update stage and reads the row store, the edge on which that stage
//   moves on loads the output register); the single read port of the row store
//   and the update datapath set the rate of one cell per cycle
// reset and stalls
//   rst clears the raster position, the stencil window and both pipeline
//   valids; row stores are not cleared, every entry is written before use
//   when out_ready is low a pending result holds and makes the update stage wait;
//   in_ready drops once that stage is also full
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hds_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input cell stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            cell_value,
  input  logic signed [31:0]            source_rate,
  // updated cell stream
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            new_value,
  output logic [$clog2(MAX_ROWS)-1:0]   row_index,
  output logic [$clog2(MAX_COLS)-1:0]   col_index,
  output logic                          last_cell
);
  import hds_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  hds_cfg_t cfg;
  logic     count_wr;

  // grid size clamped to the supported range
  logic [COL_W:0] cols;
  logic [ROW_W:0] rows;

  // raster position of the next input
  logic [COL_W-1:0] pos_c;
  logic [ROW_W-1:0] pos_r;
  logic [COL_W-1:0] eff_c;
  logic [ROW_W-1:0] eff_r;
  logic [COL_W-1:0] pos_c_next;
  logic [ROW_W-1:0] pos_r_next;
  logic             c_last;
  logic             r_last;
  logic             boundary;
  logic             in_accept;

  // update stage, holds the accepted cell while its row store data is read
  logic             s1_valid;
  logic [31:0]      s1_cell;
  logic [31:0]      s1_src;
  logic [COL_W-1:0] s1_c;
  logic [ROW_W-1:0] s1_r;
  logic             s1_emit;
  logic             s1_last;
  logic             s1_go;
  logic             out_free;

  hds_win_t  win;
  hds_line_t rd_line;
  hds_line_t wr_line;
  logic [31:0] upd_value;

  hds_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .count_wr (count_wr)
  );

  always_comb begin
    if (cfg.column_count < CNT_W'(MIN_COUNT)) begin
      cols = (COL_W+1)'(MIN_COUNT);
    end else if (32'(cfg.column_count) > 32'(MAX_COLS)) begin
      cols = (COL_W+1)'(MAX_COLS);
    end else begin
      cols = (COL_W+1)'(cfg.column_count);
    end
    if (cfg.row_count < CNT_W'(MIN_COUNT)) begin
      rows = (ROW_W+1)'(MIN_COUNT);
    end else if (32'(cfg.row_count) > 32'(MAX_ROWS)) begin
      rows = (ROW_W+1)'(MAX_ROWS);
    end else begin
      rows = (ROW_W+1)'(cfg.row_count);
    end
  end

  // position decode: wrap when out of the grid, find ring cells
  always_comb begin
    if ({1'b0, pos_c} >= cols || {1'b0, pos_r} >= rows) begin
      eff_c = '0;
      eff_r = '0;
    end else begin
      eff_c = pos_c;
      eff_r = pos_r;
    end
    c_last   = ({1'b0, eff_c} == cols - 1'b1);
    r_last   = ({1'b0, eff_r} == rows - 1'b1);
    boundary = (eff_r == '0) || r_last || (eff_c == '0) || c_last;
    if (c_last) begin
      pos_c_next = '0;
      pos_r_next = r_last ? '0 : eff_r + 1'b1;
    end else begin
      pos_c_next = eff_c + 1'b1;
      pos_r_next = eff_r;
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign s1_go     = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign in_accept = in_valid && in_ready;

  // store update: upper takes the old middle, middle takes this cell
  assign wr_line = '{upper: rd_line.middle, middle: s1_cell, source: s1_src};

  hds_linebuf #(
    .DEPTH (MAX_COLS),
    .AW    (COL_W)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (eff_c),
    .rd_data (rd_line),
    .wr_en   (s1_go),
    .wr_addr (s1_c),
    .wr_data (wr_line)
  );

  hds_update u_update (
    .win       (win),
    .right     (rd_line.middle),
    .cfg       (cfg),
    .new_value (upd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_c     <= '0;
      pos_r     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      win       <= '0;
    end else begin
      if (count_wr) begin
        pos_c <= '0;
        pos_r <= '0;
      end else if (in_accept) begin
        pos_c <= pos_c_next;
        pos_r <= pos_r_next;
      end

      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      // window shifts once per cell leaving the update stage
      if (s1_go) begin
        win.left   <= win.centre;
        win.centre <= rd_line.middle;
        win.up     <= rd_line.upper;
        win.down   <= s1_cell;
        win.src    <= rd_line.source;
      end

      if (s1_go && s1_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell <= boundary ? 32'h0 : cell_value;
      s1_src  <= source_rate;
      s1_c    <= eff_c;
      s1_r    <= eff_r;
      s1_emit <= (eff_r >= ROW_W'(2)) && (eff_c >= COL_W'(2));
      s1_last <= r_last && c_last;
    end
    if (s1_go && s1_emit) begin
      new_value <= upd_value;
      row_index <= s1_r - 1'b1;
      col_index <= s1_c - 1'b1;
      last_cell <= s1_last;
    end
  end

  // read and write of the row store never hit the same column together
  a_no_store_clash: assert property (@(posedge clk) disable iff (rst)
    s1_go && in_accept |-> s1_c != eff_c)
    else $error("row store read and write on the same column");

  // an empty update stage always takes a cell
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty update stage");

  // results only come from interior cells
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_index != '0 && col_index != '0)
    else $error("result for a boundary cell");

  // the last cell of a pass sits next to the far corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_cell |-> col_index == COL_W'(cols - 2'd2)
      && row_index == ROW_W'(rows - 2'd2))
    else $error("last_cell away from the far corner");

endmodule

### design/hds_cfg.sv
// ----------------------------------------------------------------------------
// hds_cfg
// apb register bank: grid size, time step and diffusion gains
// ----------------------------------------------------------------------------
module hds_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hds_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output hds_pkg::hds_cfg_t             cfg,
  output logic                          count_wr
);
  import hds_pkg::*;

  logic     wr;
  hds_reg_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = hds_reg_t'(paddr[ADDR_W-1:2]);

  // a new grid size restarts the raster position
  assign count_wr = wr && (idx == REG_COLUMN_COUNT || idx == REG_ROW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_count <= CNT_W'(COUNT_RESET);
      cfg.row_count    <= CNT_W'(COUNT_RESET);
      cfg.time_step    <= '0;
      cfg.x_gain       <= '0;
      cfg.y_gain       <= '0;
    end else if (wr) begin
      case (idx)
        REG_COLUMN_COUNT: cfg.column_count <= pwdata[CNT_W-1:0];
        REG_ROW_COUNT:    cfg.row_count    <= pwdata[CNT_W-1:0];
        REG_TIME_STEP:    cfg.time_step    <= pwdata[COEF_W-1:0];
        REG_X_GAIN:       cfg.x_gain       <= pwdata[COEF_W-1:0];
        REG_Y_GAIN:       cfg.y_gain       <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COLUMN_COUNT: prdata = 32'(cfg.column_count);
      REG_ROW_COUNT:    prdata = 32'(cfg.row_count);
      REG_TIME_STEP:    prdata = 32'(cfg.time_step);
      REG_X_GAIN:       prdata = 32'(cfg.x_gain);
      REG_Y_GAIN:       prdata = 32'(cfg.y_gain);
      default:          prdata = '0;
    endcase
  end

endmodule

### design/hds_linebuf.sv
// ----------------------------------------------------------------------------
// hds_linebuf
// row stores: upper row, middle row and source row, one entry per column
// ----------------------------------------------------------------------------
module hds_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output hds_pkg::hds_line_t rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  hds_pkg::hds_line_t wr_data
);
  import hds_pkg::*;

  hds_line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/hds_update.sv
// ----------------------------------------------------------------------------
// hds_update
// ftcs cell update: u + src*dt + gx*dxx + gy*dyy, rounded and saturated
// ----------------------------------------------------------------------------
module hds_update (
  input  hds_pkg::hds_win_t  win,
  input  logic [31:0]        right,
  input  hds_pkg::hds_cfg_t  cfg,
  output logic [31:0]        new_value
);
  import hds_pkg::*;

  logic signed [33:0] u34;
  logic signed [33:0] dxx;
  logic signed [33:0] dyy;
  logic signed [16:0] dt_s;
  logic signed [16:0] gx_s;
  logic signed [16:0] gy_s;
  logic signed [48:0] ps;
  logic signed [50:0] px;
  logic signed [50:0] py;
  logic signed [48:0] ps_r;
  logic signed [50:0] px_r;
  logic signed [50:0] py_r;
  logic signed [37:0] sum;

  always_comb begin
    u34  = $signed({{2{win.centre[31]}}, win.centre});
    dxx  = $signed({{2{win.left[31]}}, win.left}) + $signed({{2{right[31]}}, right})
           - (u34 <<< 1);
    dyy  = $signed({{2{win.up[31]}}, win.up}) + $signed({{2{win.down[31]}}, win.down})
           - (u34 <<< 1);
    dt_s = $signed({1'b0, cfg.time_step});
    gx_s = $signed({1'b0, cfg.x_gain});
    gy_s = $signed({1'b0, cfg.y_gain});
    ps   = $signed(win.src) * dt_s;
    px   = dxx * gx_s;
    py   = dyy * gy_s;
    // round to nearest, ties up: add half then floor
    ps_r = ps + 49'sd32768;
    px_r = px + 51'sd32768;
    py_r = py + 51'sd32768;
    sum  = $signed({{6{win.centre[31]}}, win.centre})
         + $signed({{5{ps_r[48]}}, ps_r[48:16]})
         + $signed({{3{px_r[50]}}, px_r[50:16]})
         + $signed({{3{py_r[50]}}, py_r[50:16]});
    // saturate to signed 32 bits
    if (sum[37:31] == 7'h00 || sum[37:31] == 7'h7f) begin
      new_value = sum[31:0];
    end else if (sum[37]) begin
      new_value = 32'h8000_0000;
    end else begin
      new_value = 32'h7fff_ffff;
    end
  end

endmodule

### tb/sv/hds_result_checker.sv
// ----------------------------------------------------------------------------
// hds_result_checker
// watches the configuration port and both cell streams of the stencil step
// block, predicts every updated interior cell and compares it with the output
// ----------------------------------------------------------------------------
module hds_result_checker #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hds_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [31:0]          cell_value,
  input  logic signed [31:0]          source_rate,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [31:0]          new_value,
  input  logic [$clog2(MAX_ROWS)-1:0] row_index,
  input  logic [$clog2(MAX_COLS)-1:0] col_index,
  input  logic                        last_cell,
  output int                          mismatch_count,
  output int                          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import hds_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;
  } cell_update_t;

  cell_update_t expected_cells [$];
  hds_cfg_t     cfg;
  hds_win_t     win;
  hds_line_t    line_store [MAX_COLS];
  int           col_pos;
  int           row_pos;
  int           mismatches = 0;
  int           outstanding = 0;

  assign mismatch_count  = mismatches;
  assign pending_results = outstanding;

  function automatic longint widen(logic [DATA_W-1:0] v);
    return longint'(signed'(v));
  endfunction

  // q16 product back to q16.16, nearest with ties upward
  function automatic longint round_q16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic int clamp_count(logic [CNT_W-1:0] v, int hi);
    if (v < MIN_COUNT) return MIN_COUNT;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%t %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic apply_reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    case (hds_reg_t'(addr[ADDR_W-1:2]))
      REG_COLUMN_COUNT: begin
        cfg.column_count = data[CNT_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      REG_ROW_COUNT: begin
        cfg.row_count = data[CNT_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      REG_TIME_STEP: cfg.time_step = data[COEF_W-1:0];
      REG_X_GAIN:    cfg.x_gain = data[COEF_W-1:0];
      REG_Y_GAIN:    cfg.y_gain = data[COEF_W-1:0];
      default: ;
    endcase
  endtask

  // one raster step: finish the cell left-up of this input, shift the window
  task automatic advance_grid(logic [DATA_W-1:0] cell_word, logic [DATA_W-1:0] src);
    int           cols;
    int           rows;
    int           c;
    int           r;
    logic [DATA_W-1:0] cell_in;
    hds_line_t    line;
    longint       u;
    longint       dxx;
    longint       dyy;
    longint       sum;
    cell_update_t upd;
    cols = clamp_count(cfg.column_count, MAX_COLS);
    rows = clamp_count(cfg.row_count, MAX_ROWS);
    c = col_pos;
    r = row_pos;
    if (c >= cols || r >= rows) begin
      c = 0;
      r = 0;
    end
    // boundary ring counts as zero
    cell_in = (r == 0 || r == rows - 1 || c == 0 || c == cols - 1) ? '0 : cell_word;
    line = line_store[c];
    if (r >= 2 && c >= 2) begin
      u   = widen(win.centre);
      dxx = widen(win.left) + widen(line.middle) - 2 * u;
      dyy = widen(win.up) + widen(win.down) - 2 * u;
      sum = u + round_q16(widen(win.src) * longint'(cfg.time_step))
              + round_q16(dxx * longint'(cfg.x_gain))
              + round_q16(dyy * longint'(cfg.y_gain));
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
      upd.value = sum[DATA_W-1:0];
      upd.row   = ROW_W'(r - 1);
      upd.col   = COL_W'(c - 1);
      upd.last  = (r == rows - 1 && c == cols - 1);
      expected_cells.push_back(upd);
    end
    win.left   = win.centre;
    win.centre = line.middle;
    win.up     = line.upper;
    win.down   = cell_in;
    win.src    = line.source;
    line_store[c] = '{upper: line.middle, middle: cell_in, source: src};
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic check_update();
    cell_update_t want;
    if (expected_cells.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h at (%0d,%0d)",
                                new_value, row_index, col_index));
    end else begin
      want = expected_cells.pop_front();
      if (new_value !== want.value)
        report_mismatch($sformatf("new_value at (%0d,%0d): got %h, want %h",
                                  want.row, want.col, new_value, want.value));
      if (row_index !== want.row)
        report_mismatch($sformatf("row_index: got %0d, want %0d", row_index, want.row));
      if (col_index !== want.col)
        report_mismatch($sformatf("col_index: got %0d, want %0d", col_index, want.col));
      if (last_cell !== want.last)
        report_mismatch($sformatf("last_cell at (%0d,%0d): got %b, want %b",
                                  want.row, want.col, last_cell, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{column_count: CNT_W'(COUNT_RESET), row_count: CNT_W'(COUNT_RESET),
              time_step: '0, x_gain: '0, y_gain: '0};
      win = '0;
      foreach (line_store[i]) line_store[i] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_cells.delete();
    end else begin
      // results leave from registers after their input, so check before predicting
      if (out_valid && out_ready) check_update();
      if (psel && penable && pwrite && pready) apply_reg_write(paddr, pwdata);
      if (in_valid && in_ready) advance_grid(cell_value, source_rate);
    end
    outstanding <= expected_cells.size();
  end

endmodule

### tb/sv/tb_heat_diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// tb_heat_diffusion_stencil_step
// streams grids through the stencil step block under random flow control;
// a short directed set covers saturation, rounding ties and boundary cells,
// random passes vary grid size and gains, one pass holds the receiver off
// until the input stalls; the result checker predicts and compares every
// updated cell
// ----------------------------------------------------------------------------
module tb_heat_diffusion_stencil_step;
  timeunit 1ns;
  timeprecision 1ps;
  import hds_pkg::*;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROWS     = 1024;
  localparam int RANDOM_CELLS = 1500;
  localparam int HOLD_CYCLES  = 300;   // receiver hold-off, fills the pipeline
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int IDLE_PCT     = 34;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_W-1:0]           paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [31:0]          cell_value = '0;
  logic signed [31:0]          source_rate = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [31:0]          new_value;
  logic [$clog2(MAX_ROWS)-1:0] row_index;
  logic [$clog2(MAX_COLS)-1:0] col_index;
  logic                        last_cell;
  int                          mismatch_count;
  int                          pending_results;

  // flow control knobs for the sender and receiver processes, and the quiet count
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  bit hold_off_req  = 1'b0;
  int quiet_cycles  = 0;

  always #2 clk = ~clk;

  heat_diffusion_stencil_step #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) DUT (.*);

  hds_result_checker #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_result_checker (.*);

  // ---------------------------------------------------------------------------
  // value pickers
  // ---------------------------------------------------------------------------

  // q16.16 words: extremes, unit steps, small and mid magnitudes, full range
  function automatic logic [31:0] pick_sample_word();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      4, 5: return {{12{w[19]}}, w[19:0]};
      6: return {{6{w[25]}}, w[25:0]};
      default: return w;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'h0000;
      1: return 32'hFFFF;
      2: return 32'h8000;
      3: return $urandom_range(1, 255);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // mostly small grids; sometimes below the minimum, which clamps to 3
  function automatic int pick_count();
    case ($urandom_range(9))
      0: return $urandom_range(0, 2);
      1: return 3;
      default: return $urandom_range(4, 10);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // bus tasks; each starts on a falling edge so every drive lands there
  // ---------------------------------------------------------------------------

  task automatic write_reg(hds_reg_t idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one cell, with random idle cycles ahead of it, and wait for the transfer
  task automatic send_cell(logic [31:0] cv, logic [31:0] sv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    cell_value  <= cv;
    source_rate <= sv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering, wait for every predicted cell, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    bit hold_off_done;
    stall_left = 0;
    hold_off_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any stream transfer or register write resets the quiet count
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("heat_diffusion_stencil_step: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] probe_cell [28];
    logic [31:0] probe_src  [28];
    int sent;
    int phase;
    int n_cells;
    int cols;
    int rows;
    int raw;

    // 4x4 grid (saturation both ways, nonzero boundary that must be ignored),
    // then 4x3 grid (rounding ties upward for positive and negative products)
    probe_cell = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h5555_AAAA, 32'hAAAA_5555, 32'h0001_0000, 32'hFFFF_0000,
                   32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000, 32'h0F0F_0F0F};
    probe_src  = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'hFFFF_8000,
                   32'h1234_5678, 32'h8765_4321, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                   32'h0000_0000, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'h7FFF_FFFF};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: largest gains on a 4x4 grid
    write_reg(REG_COLUMN_COUNT, 4);
    write_reg(REG_ROW_COUNT, 4);
    write_reg(REG_TIME_STEP, 32'hFFFF);
    write_reg(REG_X_GAIN, 32'hFFFF);
    write_reg(REG_Y_GAIN, 32'hFFFF);
    for (int i = 0; i < 16; i++) send_cell(probe_cell[i], probe_src[i]);
    drain_results();

    // directed: half gains on a 4x3 grid, ties on the source and horizontal terms
    write_reg(REG_ROW_COUNT, 3);
    write_reg(REG_TIME_STEP, 32'h8000);
    write_reg(REG_X_GAIN, 32'h8000);
    write_reg(REG_Y_GAIN, 32'h8000);
    for (int i = 16; i < 28; i++) send_cell(probe_cell[i], probe_src[i]);
    drain_results();

    // random passes; some stop mid-pass and the next count write restarts the raster
    sent  = 0;
    phase = 0;
    cols  = 4;
    rows  = 3;
    while (sent < RANDOM_CELLS) begin
      // two phases out of every five run with no idling on either side
      send_idle_pct = (phase % 5 >= 3) ? 0 : IDLE_PCT;
      recv_idle_pct = send_idle_pct;
      if (phase == 2) begin
        // tall enough grid that results keep coming while the receiver holds off
        cols = 8;
        rows = 10;
        write_reg(REG_COLUMN_COUNT, cols);
        write_reg(REG_ROW_COUNT, rows);
      end else if (phase == 0 || $urandom_range(3) != 0) begin
        raw = pick_count();
        write_reg(REG_COLUMN_COUNT, raw);
        cols = (raw < 3) ? 3 : raw;
        raw = pick_count();
        write_reg(REG_ROW_COUNT, raw);
        rows = (raw < 3) ? 3 : raw;
      end
      if ($urandom_range(1)) write_reg(REG_TIME_STEP, pick_gain());
      if ($urandom_range(1)) write_reg(REG_X_GAIN, pick_gain());
      if ($urandom_range(1)) write_reg(REG_Y_GAIN, pick_gain());

      // whole passes (wrapping into a second) or an arbitrary partial stretch
      if (phase != 2 && $urandom_range(3) == 0) n_cells = $urandom_range(1, 2 * cols * rows);
      else n_cells = cols * rows * $urandom_range(1, 2);

      for (int i = 0; i < n_cells; i++) begin
        if (phase == 2 && i == 40) hold_off_req = 1'b1;
        // sometimes pause mid-pass until the block has emptied
        if (phase != 2 && i == n_cells / 2 && $urandom_range(3) == 0) drain_results();
        send_cell(pick_sample_word(), pick_sample_word());
      end
      drain_results();
      sent += n_cells;
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("heat_diffusion_stencil_step: match");
    end else begin
      $display("heat_diffusion_stencil_step: mismatch");
    end
    $finish;
  end

endmodule
